### rtl/siva_pkg.sv
package siva_pkg;

	localparam int unsigned WordWidth = 64;
	localparam int unsigned WordCount = 4;
	localparam int unsigned CmdWidth = 5;
	localparam int unsigned ImmWidth = 8;

	typedef enum logic [CmdWidth-1:0] {
		CMD_AND       = 5'd0,
		CMD_ANDN      = 5'd1,
		CMD_OR        = 5'd2,
		CMD_XOR       = 5'd3,
		CMD_CMPGTB    = 5'd4,
		CMD_CMPGTW    = 5'd5,
		CMD_CMPGTD    = 5'd6,
		CMD_PACKSSDW  = 5'd7,
		CMD_UNPCKLQDQ = 5'd8,
		CMD_UNPCKHQDQ = 5'd9,
		CMD_PSHUFD    = 5'd10,
		CMD_PSRLD     = 5'd11,
		CMD_PSRAD     = 5'd12,
		CMD_PSLLD     = 5'd13,
		CMD_PSRLQ     = 5'd14,
		CMD_PSRLDQ    = 5'd15,
		CMD_PSLLQ     = 5'd16,
		CMD_PSLLDQ    = 5'd17,
		CMD_MOVE      = 5'd18,
		CMD_MOVD_TOV  = 5'd19,
		CMD_MOVD_TOG  = 5'd20,
		CMD_MOVD_TOM  = 5'd21
	} cmd_t;

	typedef struct packed {
		logic [CmdWidth-1:0]  command;
		logic [WordWidth-1:0] src_v_word0;
		logic [WordWidth-1:0] src_v_word1;
		logic [WordWidth-1:0] src_v_word2;
		logic [WordWidth-1:0] src_v_word3;
		logic [WordWidth-1:0] src_e_word0;
		logic [WordWidth-1:0] src_e_word1;
		logic [WordWidth-1:0] src_e_word2;
		logic [WordWidth-1:0] src_e_word3;
		logic [ImmWidth-1:0]  immediate;
		logic                 long_vector;
		logic                 wide_gpr;
	} req_t;

	typedef struct packed {
		logic [WordWidth-1:0] res_word0;
		logic [WordWidth-1:0] res_word1;
		logic [WordWidth-1:0] res_word2;
		logic [WordWidth-1:0] res_word3;
	} rsp_t;

	// Decoded operation class carried from the decode stage.
	typedef struct packed {
		logic is_logic;
		logic is_cmp;
		logic is_pack;
		logic is_unpck;
		logic is_shuf;
		logic is_dshift;
		logic is_qshift;
		logic is_bshift;
		logic is_move;
		logic is_gpr;
	} op_class_t;

	function automatic logic [15:0] sat16(input logic [31:0] x);
		logic [15:0] r;
		if (!x[31] && x[30:15] != 16'h0000) begin
			r = 16'h7FFF;
		end else if (x[31] && x[30:15] != 16'hFFFF) begin
			r = 16'h8000;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

endpackage

### rtl/siva_if.sv
interface siva_req_if;
	logic               valid;
	logic               ready;
	siva_pkg::req_t     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface siva_rsp_if;
	logic               valid;
	logic               ready;
	siva_pkg::rsp_t     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/simd_integer_vector_alu_256_unit.sv
// Integer SIMD unit on 256-bit operands. It takes one request per cycle unless the result
// side stalls. Stages: input register, decode, element operations, lane select, output
// register. Back-pressure on the result side stalls the whole pipeline in place, so no
// request is lost or repeated. When long_vector is low the upper 128 bits are zero.
module simd_integer_vector_alu_256_unit (
	input  logic clk,
	input  logic arst_n,
	siva_req_if.sink   req,
	siva_rsp_if.source rsp
);
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	siva_pkg::req_t req_s1, req_s2;
	siva_pkg::op_class_t op_s2;
	logic lng_s3, gpr_s3;
	logic [63:0] gpr_s3_w;
	logic [127:0] lo_r, hi_r;
	siva_pkg::rsp_t rsp_s4;

	assign adv = !v_s4 || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req.payload;
			req_s2 <= req_s1;
			op_s2.is_logic  <= req_s1.command <= siva_pkg::CMD_XOR;
			op_s2.is_cmp    <= req_s1.command >= siva_pkg::CMD_CMPGTB &&
				req_s1.command <= siva_pkg::CMD_CMPGTD;
			op_s2.is_pack   <= req_s1.command == siva_pkg::CMD_PACKSSDW;
			op_s2.is_unpck  <= req_s1.command == siva_pkg::CMD_UNPCKLQDQ ||
				req_s1.command == siva_pkg::CMD_UNPCKHQDQ;
			op_s2.is_shuf   <= req_s1.command == siva_pkg::CMD_PSHUFD;
			op_s2.is_dshift <= req_s1.command >= siva_pkg::CMD_PSRLD &&
				req_s1.command <= siva_pkg::CMD_PSLLD;
			op_s2.is_qshift <= req_s1.command == siva_pkg::CMD_PSRLQ ||
				req_s1.command == siva_pkg::CMD_PSLLQ;
			op_s2.is_bshift <= req_s1.command == siva_pkg::CMD_PSRLDQ ||
				req_s1.command == siva_pkg::CMD_PSLLDQ;
			op_s2.is_move   <= req_s1.command == siva_pkg::CMD_MOVE;
			op_s2.is_gpr    <= req_s1.command >= siva_pkg::CMD_MOVD_TOV &&
				req_s1.command <= siva_pkg::CMD_MOVD_TOM;
			lng_s3 <= req_s2.long_vector;
			gpr_s3 <= op_s2.is_gpr;
			if (req_s2.command == siva_pkg::CMD_MOVD_TOV) begin
				gpr_s3_w <= req_s2.wide_gpr ? req_s2.src_e_word0
					: {32'd0, req_s2.src_e_word0[31:0]};
			end else begin
				gpr_s3_w <= req_s2.wide_gpr ? req_s2.src_v_word0
					: {32'd0, req_s2.src_v_word0[31:0]};
			end
			if (gpr_s3) begin
				rsp_s4.res_word0 <= gpr_s3_w;
				rsp_s4.res_word1 <= 64'd0;
				rsp_s4.res_word2 <= 64'd0;
				rsp_s4.res_word3 <= 64'd0;
			end else begin
				rsp_s4.res_word0 <= lo_r[63:0];
				rsp_s4.res_word1 <= lo_r[127:64];
				rsp_s4.res_word2 <= lng_s3 ? hi_r[63:0] : 64'd0;
				rsp_s4.res_word3 <= lng_s3 ? hi_r[127:64] : 64'd0;
			end
		end
	end

	siva_lane u_lane_lo (
		.clk(clk), .en(adv), .command(siva_pkg::cmd_t'(req_s2.command)), .op(op_s2),
		.v({req_s2.src_v_word1, req_s2.src_v_word0}),
		.e({req_s2.src_e_word1, req_s2.src_e_word0}),
		.imm(req_s2.immediate), .r(lo_r)
	);

	siva_lane u_lane_hi (
		.clk(clk), .en(adv), .command(siva_pkg::cmd_t'(req_s2.command)), .op(op_s2),
		.v({req_s2.src_v_word3, req_s2.src_v_word2}),
		.e({req_s2.src_e_word3, req_s2.src_e_word2}),
		.imm(req_s2.immediate), .r(hi_r)
	);

	assign rsp.valid = v_s4;
	assign rsp.payload = rsp_s4;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !rsp.ready |=> v_s4 && $stable(rsp_s4))
		else $error("Result changed while stalled.");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> req.ready)
		else $error("Input stalled with empty output.");
	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 |=> v_s4)
		else $error("Request lost between stages.");
	a_short_upper: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 && !lng_s3 |=> rsp_s4.res_word3 == 64'd0)
		else $error("Upper half not cleared.");

endmodule

### rtl/siva_lane.sv
// Computes one 128-bit lane; registered between the element work and the lane select.
module siva_lane (
	input  logic                   clk,
	input  logic                   en,
	input  siva_pkg::cmd_t         command,
	input  siva_pkg::op_class_t    op,
	input  logic [127:0]           v,
	input  logic [127:0]           e,
	input  logic [7:0]             imm,
	output logic [127:0]           r
);
	logic [127:0] logic_r, cmp_r, pack_r, unpck_r, shuf_r, dsh_r, qsh_r, bsh_r;
	logic [127:0] logic_s, cmp_s, pack_s, unpck_s, shuf_s, dsh_s, qsh_s, bsh_s;
	siva_pkg::op_class_t op_s;
	logic [127:0] e_s;

	always_comb begin
		unique case (command)
			siva_pkg::CMD_AND:  logic_r = v & e;
			siva_pkg::CMD_ANDN: logic_r = ~v & e;
			siva_pkg::CMD_OR:   logic_r = v | e;
			default:            logic_r = v ^ e;
		endcase
	end

	always_comb begin
		cmp_r = '0;
		unique case (command)
			siva_pkg::CMD_CMPGTB: begin
				for (int i = 0; i < 16; i++) begin
					cmp_r[i*8 +: 8] = {8{$signed(v[i*8 +: 8]) > $signed(e[i*8 +: 8])}};
				end
			end
			siva_pkg::CMD_CMPGTW: begin
				for (int i = 0; i < 8; i++) begin
					cmp_r[i*16 +: 16] =
						{16{$signed(v[i*16 +: 16]) > $signed(e[i*16 +: 16])}};
				end
			end
			default: begin
				for (int i = 0; i < 4; ++i) begin
					cmp_r[i*32 +: 32] =
						{32{$signed(v[i*32 +: 32]) > $signed(e[i*32 +: 32])}};
				end
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pack_r[i*16 +: 16]      = siva_pkg::sat16(v[i*32 +: 32]);
			pack_r[64 + i*16 +: 16] = siva_pkg::sat16(e[i*32 +: 32]);
		end
		unpck_r = (command == siva_pkg::CMD_UNPCKLQDQ) ? {e[63:0], v[63:0]}
			: {e[127:64], v[127:64]};
		for (int i = 0; i < 4; i++) begin
			shuf_r[i*32 +: 32] = e[imm[i*2 +: 2]*32 +: 32];
		end
	end

	always_comb begin
		logic [4:0] c;
		c = (imm > 8'd31) ? 5'd31 : imm[4:0];
		for (int i = 0; i < 4; i++) begin
			unique case (command)
				siva_pkg::CMD_PSRAD:
					dsh_r[i*32 +: 32] = 32'($signed(e[i*32 +: 32]) >>> c);
				siva_pkg::CMD_PSRLD:
					dsh_r[i*32 +: 32] = (imm > 8'd31) ? 32'd0 : e[i*32 +: 32] >> c;
				default:
					dsh_r[i*32 +: 32] = (imm > 8'd31) ? 32'd0 : e[i*32 +: 32] << c;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			if (imm > 8'd63) begin
				qsh_r[i*64 +: 64] = '0;
			end else if (command == siva_pkg::CMD_PSRLQ) begin
				qsh_r[i*64 +: 64] = e[i*64 +: 64] >> imm[5:0];
			end else begin
				qsh_r[i*64 +: 64] = e[i*64 +: 64] << imm[5:0];
			end
		end
		if (imm > 8'd15) begin
			bsh_r = '0;
		end else if (command == siva_pkg::CMD_PSRLDQ) begin
			bsh_r = e >> {imm[3:0], 3'b000};
		end else begin
			bsh_r = e << {imm[3:0], 3'b000};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic_s <= logic_r;
			cmp_s   <= cmp_r;
			pack_s  <= pack_r;
			unpck_s <= unpck_r;
			shuf_s  <= shuf_r;
			dsh_s   <= dsh_r;
			qsh_s   <= qsh_r;
			bsh_s   <= bsh_r;
			op_s    <= op;
			e_s     <= e;
		end
	end

	always_comb begin
		r = '0;
		if (op_s.is_logic)  r = logic_s;
		if (op_s.is_cmp)    r = cmp_s;
		if (op_s.is_pack)   r = pack_s;
		if (op_s.is_unpck)  r = unpck_s;
		if (op_s.is_shuf)   r = shuf_s;
		if (op_s.is_dshift) r = dsh_s;
		if (op_s.is_qshift) r = qsh_s;
		if (op_s.is_bshift) r = bsh_s;
		if (op_s.is_move)   r = e_s;
	end

endmodule

### verif/simd_integer_vector_alu_256_unit_tb.sv
`timescale 1ns / 1ps

module simd_integer_vector_alu_256_unit_tb;

	class vector_result_board;
		siva_pkg::rsp_t pending[$];
		int errors = 0;

		function automatic logic [15:0] sat_dword(input logic [31:0] x);
			longint sv;
			sv = longint'($signed(x));
			if (sv < -32768) sv = -32768;
			if (sv > 32767) sv = 32767;
			return 16'(sv);
		endfunction

		function automatic logic [127:0] lane_result(input siva_pkg::cmd_t c,
				input logic [127:0] v, input logic [127:0] e, input logic [7:0] imm);
			logic [127:0] r;
			int w;
			int cnt;
			r = '0;
			unique case (c)
				siva_pkg::CMD_AND: r = v & e;
				siva_pkg::CMD_ANDN: r = ~v & e;
				siva_pkg::CMD_OR: r = v | e;
				siva_pkg::CMD_XOR: r = v ^ e;
				siva_pkg::CMD_CMPGTB, siva_pkg::CMD_CMPGTW, siva_pkg::CMD_CMPGTD: begin
					w = (c == siva_pkg::CMD_CMPGTB) ? 8 : (c == siva_pkg::CMD_CMPGTW) ? 16 : 32;
					for (int i = 0; i < 128; i += w) begin
						logic [31:0] a;
						logic [31:0] b;
						a = 32'(v >> i) << (32 - w);
						b = 32'(e >> i) << (32 - w);
						if ($signed(a) > $signed(b))
							for (int k = 0; k < w; k++) r[i + k] = 1'b1;
					end
				end
				siva_pkg::CMD_PACKSSDW: begin
					for (int i = 0; i < 4; i++) begin
						r[16 * i +: 16] = sat_dword(v[32 * i +: 32]);
						r[64 + 16 * i +: 16] = sat_dword(e[32 * i +: 32]);
					end
				end
				siva_pkg::CMD_UNPCKLQDQ: r = {e[63:0], v[63:0]};
				siva_pkg::CMD_UNPCKHQDQ: r = {e[127:64], v[127:64]};
				siva_pkg::CMD_PSHUFD:
					for (int i = 0; i < 4; i++) r[32 * i +: 32] = e[32 * imm[2 * i +: 2] +: 32];
				siva_pkg::CMD_PSRLD, siva_pkg::CMD_PSRAD, siva_pkg::CMD_PSLLD:
					for (int i = 0; i < 4; i++) begin
						if (c == siva_pkg::CMD_PSRAD) begin
							cnt = (imm > 31) ? 31 : imm;
							r[32 * i +: 32] = $signed(e[32 * i +: 32]) >>> cnt;
						end else if (imm <= 31) begin
							r[32 * i +: 32] = (c == siva_pkg::CMD_PSRLD) ? e[32 * i +: 32] >> imm
								: e[32 * i +: 32] << imm;
						end
					end
				siva_pkg::CMD_PSRLQ, siva_pkg::CMD_PSLLQ:
					if (imm <= 63)
						for (int i = 0; i < 2; i++)
							r[64 * i +: 64] = (c == siva_pkg::CMD_PSRLQ) ? e[64 * i +: 64] >> imm
								: e[64 * i +: 64] << imm;
				siva_pkg::CMD_PSRLDQ: if (imm <= 15) r = e >> (8 * imm);
				siva_pkg::CMD_PSLLDQ: if (imm <= 15) r = e << (8 * imm);
				siva_pkg::CMD_MOVE: r = e;
				default: r = '0;
			endcase
			return r;
		endfunction

		function automatic void note_request(input siva_pkg::req_t q);
			logic [255:0] v;
			logic [255:0] e;
			logic [255:0] r;
			siva_pkg::cmd_t c;
			siva_pkg::rsp_t x;
			v = {q.src_v_word3, q.src_v_word2, q.src_v_word1, q.src_v_word0};
			e = {q.src_e_word3, q.src_e_word2, q.src_e_word1, q.src_e_word0};
			c = siva_pkg::cmd_t'(q.command);
			r = '0;
			if (q.command <= siva_pkg::CMD_MOVE) begin
				r[127:0] = lane_result(c, v[127:0], e[127:0], q.immediate);
				if (q.long_vector)
					r[255:128] = lane_result(c, v[255:128], e[255:128], q.immediate);
			end else if (q.command == siva_pkg::CMD_MOVD_TOV) begin
				r[63:0] = q.wide_gpr ? e[63:0] : {32'h0, e[31:0]};
			end else if (q.command == siva_pkg::CMD_MOVD_TOG ||
					q.command == siva_pkg::CMD_MOVD_TOM) begin
				r[63:0] = q.wide_gpr ? v[63:0] : {32'h0, v[31:0]};
			end
			x.res_word0 = r[63:0];
			x.res_word1 = r[127:64];
			x.res_word2 = r[191:128];
			x.res_word3 = r[255:192];
			pending.push_back(x);
		endfunction

		function automatic void check_result(input siva_pkg::rsp_t a);
			siva_pkg::rsp_t x;
			if (pending.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			x = pending.pop_front();
			if (a.res_word0 !== x.res_word0) begin
				$error("res_word0 expected %h actual %h", x.res_word0, a.res_word0); errors++;
			end
			if (a.res_word1 !== x.res_word1) begin
				$error("res_word1 expected %h actual %h", x.res_word1, a.res_word1); errors++;
			end
			if (a.res_word2 !== x.res_word2) begin
				$error("res_word2 expected %h actual %h", x.res_word2, a.res_word2); errors++;
			end
			if (a.res_word3 !== x.res_word3) begin
				$error("res_word3 expected %h actual %h", x.res_word3, a.res_word3); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	siva_req_if req ();
	siva_rsp_if rsp ();
	vector_result_board board = new();
	bit sending_done = 1'b0;
	int hold_off = 0;

	simd_integer_vector_alu_256_unit dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.payload = '0;
		rsp.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: w = '0;
			1: w = '1;
			2: w = 64'h8000_0000_8000_0000;
			3: w = 64'h7FFF_FFFF_7FFF_FFFF;
			4: w = {$urandom_range(0, 1) ? 32'hFFFF_8000 : 32'h0000_7FFF,
				$urandom_range(0, 1) ? 32'h0000_8000 : 32'hFFFF_7FFF};
			default: ;
		endcase
		return w;
	endfunction

	function automatic siva_pkg::req_t rand_request();
		siva_pkg::req_t q;
		q.command = 5'($urandom_range(0, 31));
		if ($urandom_range(0, 9) != 0) q.command = 5'($urandom_range(0, 21));
		q.src_v_word0 = rand_word(); q.src_v_word1 = rand_word();
		q.src_v_word2 = rand_word(); q.src_v_word3 = rand_word();
		q.src_e_word0 = rand_word(); q.src_e_word1 = rand_word();
		q.src_e_word2 = rand_word(); q.src_e_word3 = rand_word();
		case ($urandom_range(0, 3))
			0: q.immediate = 8'($urandom_range(0, 16));
			1: q.immediate = 8'($urandom_range(28, 66));
			default: q.immediate = 8'($urandom_range(0, 255));
		endcase
		q.long_vector = 1'($urandom_range(0, 1));
		q.wide_gpr = 1'($urandom_range(0, 1));
		return q;
	endfunction

	task automatic send_request(input siva_pkg::req_t q, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.payload <= q;
		do @(posedge clk); while (!req.ready);
		board.note_request(q);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		siva_pkg::req_t q;
		@(posedge arst_n);
		@(posedge clk);
		for (int c = 0; c < 24; c++) begin
			q = rand_request();
			q.command = 5'(c);
			q.long_vector = c[0];
			q.wide_gpr = c[1];
			if (c == siva_pkg::CMD_PSRLDQ || c == siva_pkg::CMD_PSLLDQ) q.immediate = 8'd0;
			if (c == 22 || c == 23) q.immediate = 8'hFF;
			send_request(q, 1'b0);
		end
		for (int i = 0; i < 8; i++) begin
			q = rand_request();
			q.command = (i % 2) ? siva_pkg::CMD_PSRAD : siva_pkg::CMD_PSRLDQ;
			q.immediate = (i < 4) ? 8'd16 : 8'd255;
			q.long_vector = 1'b1;
			send_request(q, 1'b1);
		end
		drain_results();
		for (int n = 0; n < 1900; n++) begin
			if (n == 900) drain_results();
			if (n == 300) hold_off = 80;
			send_request(rand_request(), (n >= 300 && n < 340) || (n % 200 < 30));
		end
		req.valid <= 1'b0;
		sending_done = 1'b1;
	end

	initial begin
		int stall;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				rsp.ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			board.check_result(rsp.payload);
		end
	end

	initial begin
		wait (sending_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
